>>> sv/mav_pkg.sv
// Shared types, constants and AES helper functions for the Milenage unit.
package mav_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_KEY_HI  = 3'd0;
  localparam logic [2:0] REG_KEY_LO  = 3'd1;
  localparam logic [2:0] REG_OP_HI   = 3'd2;
  localparam logic [2:0] REG_OP_LO   = 3'd3;
  localparam logic [2:0] REG_OP_MODE = 3'd4;

  // Request types
  localparam logic REQ_GENERATE = 1'b0;
  localparam logic REQ_VERIFY   = 1'b1;

  // Status codes
  localparam logic STAT_OK       = 1'b0;
  localparam logic STAT_MISMATCH = 1'b1;

  // Output block constants c2..c4 (c1 is zero), xored into the last byte
  localparam logic [127:0] C_OUT2 = 128'd1;
  localparam logic [127:0] C_OUT3 = 128'd2;
  localparam logic [127:0] C_OUT4 = 128'd4;

  localparam int unsigned AES_ROUNDS = 10;

  typedef struct packed {
    logic         req_type;
    logic [127:0] rand_val;
    logic [47:0]  sqn;
    logic [15:0]  amf;
    logic [63:0]  mac;
  } req_t;

  typedef struct packed {
    logic [127:0] key;
    logic [127:0] op;
    logic         op_mode;
  } cfg_t;

  typedef struct packed {
    logic         status;
    logic [63:0]  mac_a;
    logic [47:0]  anon_key;
    logic [63:0]  response;
    logic [127:0] cipher_key;
    logic [127:0] integrity_key;
    logic [47:0]  sqn_out;
  } res_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // One key schedule step: next round key from the current one
  function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
    w0 = rk[127:96];
    w1 = rk[95:64];
    w2 = rk[63:32];
    w3 = rk[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // SubBytes, ShiftRows and (unless last) MixColumns; byte 0 is the top byte
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0]   u [0:15];
    logic [7:0]   a0, a1, a2, a3, t;
    logic [127:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        u[c*4+k] = SBOX[s[127 - 8*(((c+k) % 4)*4 + k) -: 8]];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = u[c*4];
        a1 = u[c*4+1];
        a2 = u[c*4+2];
        a3 = u[c*4+3];
        t  = a0 ^ a1 ^ a2 ^ a3;
        u[c*4]   = a0 ^ t ^ xt(a0 ^ a1);
        u[c*4+1] = a1 ^ t ^ xt(a1 ^ a2);
        u[c*4+2] = a2 ^ t ^ xt(a2 ^ a3);
        u[c*4+3] = a3 ^ t ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127 - 8*i -: 8] = u[i];
    end
    return r;
  endfunction

endpackage

>>> sv/mav_front.sv
// Request intake: accepts words and holds them in a two-entry queue.
module mav_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mav_pkg::req_t in_req,
  output logic          q_valid,
  input  logic          q_pop,
  output mav_pkg::req_t q_req
);
  import mav_pkg::*;

  req_t       mem_r [0:1];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_req    = mem_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_req;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> count_r != 2'd0) else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers out of step");

endmodule

>>> sv/mav_aes.sv
// Round-iterative AES-128 encryption core with on-the-fly key schedule.
module mav_aes (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] key,
  input  logic [127:0] blk,
  output logic         done,
  output logic [127:0] res
);
  import mav_pkg::*;

  logic         busy_r, done_r;
  logic [3:0]   rnd_r;
  logic [7:0]   rcon_r;
  logic [127:0] state_r, rk_r;
  logic [127:0] rk_nxt;
  logic         last;

  assign rk_nxt = key_step(rk_r, rcon_r);
  assign last   = (rnd_r == 4'(AES_ROUNDS));
  assign done   = done_r;
  assign res    = state_r;

  // Data path: one round per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      state_r <= blk ^ key;
      rk_r    <= key;
      rcon_r  <= 8'h01;
    end else if (busy_r) begin
      state_r <= aes_round(state_r, last) ^ rk_nxt;
      rk_r    <= rk_nxt;
      rcon_r  <= xt(rcon_r);
    end
  end

  // Round control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= 4'd1;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 4'd1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("start while busy");
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r) else $error("done without final round");
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rnd_r != 4'd0 && rnd_r <= 4'(AES_ROUNDS))) else $error("round count off");

endmodule

>>> sv/mav_back.sv
// Milenage sequencer: runs the encryptions of one request and holds the result word.
module mav_back (
  input  logic          clk,
  input  logic          rst_n,
  input  mav_pkg::cfg_t cfg,
  input  logic          q_valid,
  output logic          q_pop,
  input  mav_pkg::req_t q_req,
  output logic          out_valid,
  input  logic          out_ready,
  output mav_pkg::res_t out_res
);
  import mav_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_ENC  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  typedef enum logic [5:0] {
    PH_OPC  = 6'b000001,
    PH_TEMP = 6'b000010,
    PH_OUT2 = 6'b000100,
    PH_OUT1 = 6'b001000,
    PH_OUT3 = 6'b010000,
    PH_OUT4 = 6'b100000
  } phase_t;

  state_t       state_r;
  phase_t       phase_r;
  req_t         req_r;
  logic [127:0] opc_r, temp_r, out1_r, out2_r, out3_r, out4_r;
  logic [47:0]  sqn_r;
  res_t         res_r;
  logic         out_valid_r;

  logic [127:0] y, in1, blk, enc_res, enc_out;
  logic         enc_done, start, out_load, mismatch;

  assign y       = temp_r ^ opc_r;
  assign in1     = {sqn_r, req_r.amf, sqn_r, req_r.amf};
  assign start   = (state_r == ST_LOAD);
  assign enc_out = enc_res ^ opc_r;
  assign q_pop   = (state_r == ST_IDLE) && q_valid;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign mismatch = (req_r.req_type == REQ_VERIFY) && (out1_r[127:64] != req_r.mac);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // Block fed to the cipher for each phase
  always_comb begin
    case (phase_r)
      PH_OPC:  blk = opc_r;
      PH_TEMP: blk = req_r.rand_val ^ opc_r;
      PH_OUT2: blk = y ^ C_OUT2;
      PH_OUT1: blk = in1 ^ {opc_r[63:0], opc_r[127:64]} ^ temp_r;
      PH_OUT3: blk = {y[95:0], y[127:96]} ^ C_OUT3;
      PH_OUT4: blk = {y[63:0], y[127:64]} ^ C_OUT4;
      default: blk = '0;
    endcase
  end

  mav_aes u_aes (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .key   (cfg.key),
    .blk   (blk),
    .done  (enc_done),
    .res   (enc_res)
  );

  // Working registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      req_r <= q_req;
      sqn_r <= q_req.sqn;
      opc_r <= cfg.op;
    end else if (state_r == ST_ENC && enc_done) begin
      case (phase_r)
        PH_OPC:  opc_r  <= enc_res ^ opc_r;
        PH_TEMP: temp_r <= enc_res;
        PH_OUT2: begin
          out2_r <= enc_out;
          if (req_r.req_type == REQ_VERIFY) sqn_r <= sqn_r ^ enc_out[127:80];
        end
        PH_OUT1: out1_r <= enc_out;
        PH_OUT3: out3_r <= enc_out;
        PH_OUT4: out4_r <= enc_out;
        default: ;
      endcase
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (mismatch) begin
        res_r        <= '0;
        res_r.status <= STAT_MISMATCH;
      end else begin
        res_r.status        <= STAT_OK;
        res_r.mac_a         <= out1_r[127:64];
        res_r.anon_key      <= out2_r[127:80];
        res_r.response      <= out2_r[63:0];
        res_r.cipher_key    <= out3_r;
        res_r.integrity_key <= out4_r;
        res_r.sqn_out       <= sqn_r;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_TEMP;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            phase_r <= cfg.op_mode ? PH_OPC : PH_TEMP;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: state_r <= ST_ENC;
        ST_ENC: begin
          if (enc_done) begin
            state_r <= ST_LOAD;
            case (phase_r)
              PH_OPC:  phase_r <= PH_TEMP;
              PH_TEMP: phase_r <= PH_OUT2;
              PH_OUT2: phase_r <= PH_OUT1;
              PH_OUT1: phase_r <= PH_OUT3;
              PH_OUT3: phase_r <= PH_OUT4;
              PH_OUT4: state_r <= ST_DONE;
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_DONE: begin
          if (out_load) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_done_in_enc: assert property (@(posedge clk) disable iff (!rst_n)
    enc_done |-> state_r == ST_ENC) else $error("cipher result outside encrypt state");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == ST_LOAD) else $error("pop did not start a request");
  a_mismatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.status == STAT_MISMATCH |-> res_r.mac_a == '0 && res_r.sqn_out == '0)
    else $error("mismatch word carries data");

endmodule

>>> sv/milenage_auth_vector_unit.sv
// Top level of the Milenage f1-f5 authentication vector unit.
// Requests enter a two-entry queue and are served one at a time by a sequencer around a
// single AES-128 core that does one round per clock. A request runs five encryptions with
// OPc configured directly and six when OPc is derived from OP. New requests are taken into
// the queue while one is in work, and a finished result word waits in an output register
// while the next request is worked on; that request's result waits in the sequencer until
// the word is taken. Verify requests return status 1 and all-zero fields when the
// recomputed MAC-A differs from the one supplied.
module milenage_auth_vector_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [63:0] in_rand_hi,
  input  logic [63:0] in_rand_lo,
  input  logic [47:0] in_sqn_field,
  input  logic [15:0] in_amf,
  input  logic [63:0] in_autn_mac,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [63:0] out_mac_a,
  output logic [47:0] out_anon_key,
  output logic [63:0] out_response,
  output logic [63:0] out_cipher_key_hi,
  output logic [63:0] out_cipher_key_lo,
  output logic [63:0] out_integrity_key_hi,
  output logic [63:0] out_integrity_key_lo,
  output logic [47:0] out_sqn_out
);
  import mav_pkg::*;

  cfg_t cfg_r;
  req_t in_req, q_req;
  res_t res;
  logic q_valid, q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_KEY_HI:  cfg_r.key[127:64] <= cfg_wdata;
        REG_KEY_LO:  cfg_r.key[63:0]   <= cfg_wdata;
        REG_OP_HI:   cfg_r.op[127:64]  <= cfg_wdata;
        REG_OP_LO:   cfg_r.op[63:0]    <= cfg_wdata;
        REG_OP_MODE: cfg_r.op_mode     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_req = '{req_type: in_req_type, rand_val: {in_rand_hi, in_rand_lo},
                    sqn: in_sqn_field, amf: in_amf, mac: in_autn_mac};

  mav_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_req    (q_req)
  );

  mav_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_req     (q_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  // Result word unpacking
  assign out_status           = res.status;
  assign out_mac_a            = res.mac_a;
  assign out_anon_key         = res.anon_key;
  assign out_response         = res.response;
  assign out_cipher_key_hi    = res.cipher_key[127:64];
  assign out_cipher_key_lo    = res.cipher_key[63:0];
  assign out_integrity_key_hi = res.integrity_key[127:64];
  assign out_integrity_key_lo = res.integrity_key[63:0];
  assign out_sqn_out          = res.sqn_out;

endmodule
